[hw/rtl/pvd_pkg.sv]
// ----------------------------------------------------------------------------
// pvd_pkg
// Shared types and constants of the pixel value differencing pair embedder.
// ----------------------------------------------------------------------------
`default_nettype none

package pvd_pkg;

  // Default depth of the message bit buffer.
  localparam int unsigned BUFFER_BITS = 64;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Request operation codes.
  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_EMBED  = 1'b1
  } opcode_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_EMBEDDED = 3'd0,
    ST_COMPLETE = 3'd1,
    ST_PASS     = 3'd2,
    ST_BYTE_OK  = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  // A classified request as the front part hands it to the back part.
  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] message_byte;
    logic       message_end;
    logic [7:0] first_value;
    logic [7:0] second_value;
    logic       first_ge;   // first_value >= second_value
    logic [7:0] diff;       // absolute difference of the pair
    logic [2:0] nbits;      // bits the difference range carries
    logic [7:0] base;       // lower bound of the difference range
  } cls_t;

endpackage

`default_nettype wire

[hw/rtl/pvd_req_if.sv]
// ----------------------------------------------------------------------------
// pvd_req_if
// Request channel of the embedder: valid/ready handshake and request fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface pvd_req_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] message_byte;
  logic       message_end;
  logic [7:0] first_value;
  logic [7:0] second_value;

  modport source (
    output valid, opcode, message_byte, message_end, first_value, second_value,
    input  ready
  );

  modport sink (
    input  valid, opcode, message_byte, message_end, first_value, second_value,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/pvd_rsp_if.sv]
// ----------------------------------------------------------------------------
// pvd_rsp_if
// Result channel of the embedder: valid/ready handshake and result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface pvd_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] new_first;
  logic [7:0] new_second;
  logic [2:0] bits_used;
  logic [2:0] status;

  modport source (
    output valid, new_first, new_second, bits_used, status,
    input  ready
  );

  modport sink (
    input  valid, new_first, new_second, bits_used, status,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/pvd_pair_embedder_core.sv]
// ----------------------------------------------------------------------------
// pvd_pair_embedder_core
// Pixel value differencing embedder for pairs of 8-bit channel values.
// ----------------------------------------------------------------------------
// Send message bytes (opcode 0) and channel pairs (opcode 1) on req_i; every
// request gives exactly one result on rsp_o, in order. While rsp_o is not
// stalled the block sustains one request per clock: the front part classifies
// a pair by its difference range in the accepting cycle, a two-entry queue
// decouples it from the back part, and the back part updates the message bit
// buffer once per request, then moves the pair values in a second register
// stage. A request passes through the queue, the buffer-step register and the
// output register; the single bit buffer update per request sets this rate.
`default_nettype none

module pvd_pair_embedder_core #(
  parameter int unsigned BufferBits = pvd_pkg::BUFFER_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pvd_req_if.sink    req_i,
  pvd_rsp_if.source  rsp_o
);

  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  pvd_pkg::cls_t cls;
  pvd_pkg::cls_t head;

  // Front part: handshake and range classification.
  pvd_front u_front (
    .req_i  (req_i),
    .full_i (full),
    .push_o (push),
    .cls_o  (cls)
  );

  // Queue between the parts.
  pvd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cls),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  // Back part: bit buffer, embedding and results.
  pvd_back #(
    .BufferBits (BufferBits)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .rsp_o   (rsp_o)
  );

endmodule

`default_nettype wire

[hw/rtl/pvd_front.sv]
// ----------------------------------------------------------------------------
// pvd_front
// Accepts requests and classifies channel pairs by their difference range.
// ----------------------------------------------------------------------------
`default_nettype none

module pvd_front (
  pvd_req_if.sink         req_i,
  input  logic            full_i,
  output logic            push_o,
  output pvd_pkg::cls_t   cls_o
);

  logic       first_ge;
  logic [7:0] diff;
  logic [2:0] nbits;
  logic [7:0] base;

  // A request is taken whenever the queue has room.
  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i;

  // Absolute difference of the pair.
  assign first_ge = req_i.first_value >= req_i.second_value;
  assign diff     = first_ge ? (req_i.first_value - req_i.second_value)
                             : (req_i.second_value - req_i.first_value);

  // Range lookup: the top set bit of the difference selects the range.
  always_comb begin
    priority if (diff[7]) begin
      nbits = 3'd7;
      base  = 8'd128;
    end else if (diff[6]) begin
      nbits = 3'd6;
      base  = 8'd64;
    end else if (diff[5]) begin
      nbits = 3'd5;
      base  = 8'd32;
    end else if (diff[4]) begin
      nbits = 3'd4;
      base  = 8'd16;
    end else if (diff[3]) begin
      nbits = 3'd3;
      base  = 8'd8;
    end else begin
      nbits = 3'd3;
      base  = 8'd0;
    end
  end

  // Pack the classified request.
  always_comb begin
    cls_o.opcode       = pvd_pkg::opcode_e'(req_i.opcode);
    cls_o.message_byte = req_i.message_byte;
    cls_o.message_end  = req_i.message_end;
    cls_o.first_value  = req_i.first_value;
    cls_o.second_value = req_i.second_value;
    cls_o.first_ge     = first_ge;
    cls_o.diff         = diff;
    cls_o.nbits        = nbits;
    cls_o.base         = base;
  end

endmodule

`default_nettype wire

[hw/rtl/pvd_queue.sv]
// ----------------------------------------------------------------------------
// pvd_queue
// Short first-in first-out queue of classified requests between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module pvd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pvd_pkg::cls_t   push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output pvd_pkg::cls_t   head_o
);

  localparam int unsigned Depth = pvd_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  pvd_pkg::cls_t entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign head_o  = entries_q[rd_ptr_q];

  // Pointer and fill count update, wrapping at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pvd_back.sv]
// ----------------------------------------------------------------------------
// pvd_back
// Holds the message bit buffer, embeds bits into pairs and drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module pvd_back #(
  parameter int unsigned BufferBits = pvd_pkg::BUFFER_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  pvd_pkg::cls_t   head_i,
  output logic            pop_o,
  pvd_rsp_if.source       rsp_o
);

  localparam int unsigned CntW = $clog2(BufferBits + 1);

  // Work of one request after the buffer step, before the value moves.
  typedef struct packed {
    logic [7:0]       first;
    logic [7:0]       second;
    logic             up1;     // first value moves up
    logic [7:0]       a1;      // steps for the first value
    logic [7:0]       a2;      // steps for the second value
    logic [2:0]       used;
    pvd_pkg::status_e status;
  } ex_t;

  typedef struct packed {
    logic [7:0] val;
    logic [7:0] rem;
  } mv_t;

  // Move a value by up to n steps toward 255 or 0; report the leftover steps.
  function automatic mv_t move_clamped(logic [7:0] v, logic up, logic [7:0] n);
    logic [7:0] room;
    logic [7:0] step;
    mv_t        res;
    room    = up ? (8'd255 - v) : v;
    step    = (n < room) ? n : room;
    res.val = up ? (v + step) : (v - step);
    res.rem = n - step;
    return res;
  endfunction

  // Buffer state: oldest bit at the top of the vector.
  logic [BufferBits-1:0] bits_q, bits_d;
  logic [CntW-1:0]       count_q, count_d;
  logic                  end_rcv_q, end_rcv_d;
  logic                  done_q, done_d;
  logic                  final_bit_q, final_bit_d;

  logic ex_valid_q;
  ex_t  ex_q, ex_d;
  logic out_valid_q;
  logic adv_out, ex_free;

  logic [7:0] out_first_q, out_second_q;
  logic [2:0] out_used_q;
  logic [2:0] out_status_q;

  // Pipeline flow control.
  assign adv_out = !out_valid_q || rsp_o.ready;
  assign ex_free = !ex_valid_q || adv_out;
  assign pop_o   = !empty_i && ex_free;

  // Buffer step: append a byte or take the bits for one pair.
  always_comb begin
    logic [CntW:0]  sum;
    logic           overflow;
    logic           short_field;
    logic           pass;
    logic [6:0]     win;
    logic [6:0]     hv;
    logic [2:0]     used;
    logic [7:0]     target;
    logic [7:0]     delta;
    logic           shrink;
    logic [8:0]     half_up;

    bits_d      = bits_q;
    count_d     = count_q;
    end_rcv_d   = end_rcv_q;
    done_d      = done_q;
    final_bit_d = final_bit_q;

    sum         = {1'b0, count_q} + (CntW + 1)'(8);
    overflow    = end_rcv_q || (sum > (CntW + 1)'(BufferBits));
    short_field = count_q < CntW'(head_i.nbits);
    pass        = done_q || (count_q == '0) || (short_field && !end_rcv_q);

    // Next seven bits in order, padded with the last message bit.
    for (int i = 0; i < 7; i++) begin
      win[6 - i] = (CntW'(i) < count_q) ? bits_q[BufferBits - 1 - i] : final_bit_q;
    end
    hv      = win >> (3'd7 - head_i.nbits);
    used    = short_field ? count_q[2:0] : head_i.nbits;
    target  = head_i.base | {1'b0, hv};
    shrink  = head_i.diff >= target;
    delta   = shrink ? (head_i.diff - target) : (target - head_i.diff);
    half_up = {1'b0, delta} + 9'd1;

    ex_d.first  = head_i.first_value;
    ex_d.second = head_i.second_value;
    ex_d.up1    = 1'b0;
    ex_d.a1     = '0;
    ex_d.a2     = '0;
    ex_d.used   = '0;
    ex_d.status = pvd_pkg::ST_PASS;

    if (pop_o) begin
      unique case (head_i.opcode)
        pvd_pkg::OP_APPEND: begin
          if (overflow) begin
            ex_d.status = pvd_pkg::ST_OVERFLOW;
          end else begin
            bits_d  = bits_q | ({head_i.message_byte, {(BufferBits - 8){1'b0}}} >> count_q);
            count_d = sum[CntW-1:0];
            if (head_i.message_end) begin
              end_rcv_d   = 1'b1;
              final_bit_d = head_i.message_byte[0];
            end
            ex_d.status = pvd_pkg::ST_BYTE_OK;
          end
        end
        pvd_pkg::OP_EMBED: begin
          if (!pass) begin
            bits_d      = bits_q << used;
            count_d     = count_q - CntW'(used);
            ex_d.used   = used;
            ex_d.up1    = shrink ? !head_i.first_ge : head_i.first_ge;
            ex_d.a1     = half_up[8:1];
            ex_d.a2     = {1'b0, delta[7:1]};
            if (end_rcv_q && (count_q == CntW'(used))) begin
              done_d      = 1'b1;
              ex_d.status = pvd_pkg::ST_COMPLETE;
            end else begin
              ex_d.status = pvd_pkg::ST_EMBEDDED;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q      <= '0;
      count_q     <= '0;
      end_rcv_q   <= 1'b0;
      done_q      <= 1'b0;
      final_bit_q <= 1'b0;
      ex_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      bits_q      <= bits_d;
      count_q     <= count_d;
      end_rcv_q   <= end_rcv_d;
      done_q      <= done_d;
      final_bit_q <= final_bit_d;
      if (ex_free) begin
        ex_valid_q <= pop_o;
      end
      if (adv_out) begin
        out_valid_q <= ex_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ex_q <= ex_d;
    end
  end

  // Value moves: split change, then spill what one side could not take.
  mv_t m1, m2, m3;
  logic [7:0] fin_first, fin_second;

  always_comb begin
    m1         = move_clamped(ex_q.first, ex_q.up1, ex_q.a1);
    m2         = move_clamped(ex_q.second, !ex_q.up1, ex_q.a2);
    fin_first  = m1.val;
    fin_second = m2.val;
    m3         = m2;
    if (m1.rem != '0) begin
      m3         = move_clamped(m2.val, !ex_q.up1, m1.rem);
      fin_second = m3.val;
    end else if (m2.rem != '0) begin
      m3         = move_clamped(m1.val, ex_q.up1, m2.rem);
      fin_first  = m3.val;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (adv_out && ex_valid_q) begin
      out_first_q  <= fin_first;
      out_second_q <= fin_second;
      out_used_q   <= ex_q.used;
      out_status_q <= ex_q.status;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.new_first  = out_first_q;
  assign rsp_o.new_second = out_second_q;
  assign rsp_o.bits_used  = out_used_q;
  assign rsp_o.status     = out_status_q;

endmodule

`default_nettype wire

[bench/pvd_pair_embedder_core_test.sv]
// ----------------------------------------------------------------------------
// pvd_pair_embedder_core_test
// Self-checking bench for the pixel value differencing pair embedder. Message
// bytes and channel pairs are pushed through the request channel, every result
// is compared field by field against an in-bench model of the bit buffer and
// the difference split, and both sides of the handshake stall at random.
// ----------------------------------------------------------------------------
module pvd_pair_embedder_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 100000;
  localparam int LONG_HOLD_CYCLES = 300;

  // One request as the bench builds it.
  typedef struct {
    pvd_pkg::opcode_e opcode;
    logic [7:0]       message_byte;
    logic             message_end;
    logic [7:0]       first_value;
    logic [7:0]       second_value;
  } req_item_t;

  // One result as the model predicts it.
  typedef struct {
    logic [7:0]       new_first;
    logic [7:0]       new_second;
    logic [2:0]       bits_used;
    pvd_pkg::status_e status;
  } pair_result_t;

  logic clk_i;
  logic rst_ni;

  pvd_req_if req_ch ();
  pvd_rsp_if rsp_ch ();

  pvd_pair_embedder_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  // Model state: queued message bits, oldest first.
  bit msg_bits[$];
  bit end_seen;
  bit msg_done;
  bit last_bit;

  pair_result_t expected_pairs[$];

  int fail_count;
  int cycle_count;
  int requests_sent;
  int status_hits[5];

  // Idling controls of the sender and the receiver.
  bit tx_idle_on;
  bit rx_idle_on;
  bit long_hold_pending;
  int hold_left;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_pairs.size());
      $display("[pvd_pair_embedder_core] ERROR");
      $finish;
    end
  end

  // Move a value up to n steps toward 255 or 0 and return what did not fit.
  function automatic int move_clamped(inout int v, input int dir, input int n);
    int room;
    int step;
    room = (dir > 0) ? 255 - v : v;
    step = (n < room) ? n : room;
    v = v + dir * step;
    return n - step;
  endfunction

  // Update the model with one accepted request and return its result.
  function automatic pair_result_t embed_predict(req_item_t it);
    pair_result_t res;
    int v1, v2, d, nbits, base, hv, used, target, gap, dir1, r1, r2;
    v1 = it.first_value;
    v2 = it.second_value;
    res.bits_used = 3'd0;
    if (it.opcode == pvd_pkg::OP_APPEND) begin
      if (end_seen || msg_bits.size() + 8 > pvd_pkg::BUFFER_BITS) begin
        res.status = pvd_pkg::ST_OVERFLOW;
      end else begin
        for (int i = 7; i >= 0; i--) msg_bits.insert(msg_bits.size(), it.message_byte[i]);
        if (it.message_end) begin
          end_seen = 1'b1;
          last_bit = it.message_byte[0];
        end
        res.status = pvd_pkg::ST_BYTE_OK;
      end
    end else begin
      d = (v1 >= v2) ? v1 - v2 : v2 - v1;
      if (d < 8) begin
        nbits = 3; base = 0;
      end else if (d < 16) begin
        nbits = 3; base = 8;
      end else if (d < 32) begin
        nbits = 4; base = 16;
      end else if (d < 64) begin
        nbits = 5; base = 32;
      end else if (d < 128) begin
        nbits = 6; base = 64;
      end else begin
        nbits = 7; base = 128;
      end
      if (msg_done || msg_bits.size() == 0 || (msg_bits.size() < nbits && !end_seen)) begin
        res.status = pvd_pkg::ST_PASS;
      end else begin
        // Short final fields repeat the last message bit.
        hv = 0;
        for (int i = 0; i < nbits; i++) begin
          hv = (hv << 1) | ((i < msg_bits.size()) ? msg_bits[i] : last_bit);
        end
        used = (msg_bits.size() < nbits) ? msg_bits.size() : nbits;
        repeat (used) void'(msg_bits.pop_front());
        target = base | hv;
        gap = (d >= target) ? d - target : target - d;
        if (d >= target) dir1 = (v1 >= v2) ? -1 : 1;
        else dir1 = (v1 >= v2) ? 1 : -1;
        // Ceil part to the first value, floor part to the second, spill the rest.
        r1 = move_clamped(v1, dir1, (gap + 1) >> 1);
        r2 = move_clamped(v2, -dir1, gap >> 1);
        if (r1 != 0) void'(move_clamped(v2, -dir1, r1));
        else if (r2 != 0) void'(move_clamped(v1, dir1, r2));
        res.bits_used = 3'(used);
        if (end_seen && msg_bits.size() == 0) begin
          msg_done = 1'b1;
          res.status = pvd_pkg::ST_COMPLETE;
        end else begin
          res.status = pvd_pkg::ST_EMBEDDED;
        end
      end
    end
    res.new_first = 8'(v1);
    res.new_second = 8'(v2);
    status_hits[int'(res.status)]++;
    return res;
  endfunction

  function automatic req_item_t make_item(pvd_pkg::opcode_e op, logic [7:0] mbyte,
                                          logic mend, logic [7:0] a, logic [7:0] b);
    req_item_t it;
    it.opcode = op;
    it.message_byte = mbyte;
    it.message_end = mend;
    it.first_value = a;
    it.second_value = b;
    return it;
  endfunction

  // A pair whose difference falls in a random range, often touching 0 or 255.
  function automatic req_item_t random_pair();
    int lo, hi, d, low_v;
    case ($urandom_range(0, 5))
      0: begin lo = 0; hi = 7; end
      1: begin lo = 8; hi = 15; end
      2: begin lo = 16; hi = 31; end
      3: begin lo = 32; hi = 63; end
      4: begin lo = 64; hi = 127; end
      default: begin lo = 128; hi = 255; end
    endcase
    d = $urandom_range(lo, hi);
    case ($urandom_range(0, 3))
      0: low_v = 0;
      1: low_v = 255 - d;
      default: low_v = $urandom_range(0, 255 - d);
    endcase
    if ($urandom_range(0, 1) == 1)
      return make_item(pvd_pkg::OP_EMBED, 8'($urandom), 1'($urandom), 8'(low_v + d),
                       8'(low_v));
    return make_item(pvd_pkg::OP_EMBED, 8'($urandom), 1'($urandom), 8'(low_v),
                     8'(low_v + d));
  endfunction

  // Offer one request, wait for the handshake, then record its expected result.
  task automatic send_request(input req_item_t it);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.opcode       <= it.opcode;
    req_ch.message_byte <= it.message_byte;
    req_ch.message_end  <= it.message_end;
    req_ch.first_value  <= it.first_value;
    req_ch.second_value <= it.second_value;
    do @(posedge clk_i); while (!req_ch.ready);
    expected_pairs.insert(expected_pairs.size(), embed_predict(it));
    requests_sent++;
  endtask

  // Stop offering requests until every result has come back.
  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (expected_pairs.size() > 0);
  endtask

  // Keep the buffer busy: append more often when it runs low. The end flag is
  // only set on bytes that a full buffer drops, so the message stays open.
  task automatic send_stream_item();
    int fill;
    int append_pct;
    fill = msg_bits.size();
    append_pct = (fill < 8) ? 70 : (fill > 48) ? 10 : 35;
    if ($urandom_range(0, 99) < append_pct) begin
      send_request(make_item(pvd_pkg::OP_APPEND, 8'($urandom),
                             (fill + 8 > pvd_pkg::BUFFER_BITS) ? 1'($urandom) : 1'b0,
                             8'($urandom), 8'($urandom)));
    end else begin
      send_request(random_pair());
    end
  endtask

  task automatic check_result();
    pair_result_t want;
    if (expected_pairs.size() == 0) begin
      $error("result with no request outstanding: new_first=%0d new_second=%0d status=%0d",
             rsp_ch.new_first, rsp_ch.new_second, rsp_ch.status);
      fail_count++;
    end else begin
      want = expected_pairs.pop_front();
      if (rsp_ch.new_first !== want.new_first) begin
        $error("new_first: expected %0d, got %0d", want.new_first, rsp_ch.new_first);
        fail_count++;
      end
      if (rsp_ch.new_second !== want.new_second) begin
        $error("new_second: expected %0d, got %0d", want.new_second, rsp_ch.new_second);
        fail_count++;
      end
      if (rsp_ch.bits_used !== want.bits_used) begin
        $error("bits_used: expected %0d, got %0d", want.bits_used, rsp_ch.bits_used);
        fail_count++;
      end
      if (rsp_ch.status !== want.status) begin
        $error("status: expected %s, got %0d", want.status.name(), rsp_ch.status);
        fail_count++;
      end
    end
  endtask

  // Result side: check each accepted result, then decide whether to stall.
  initial begin
    rsp_ch.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_ch.valid && rsp_ch.ready) check_result();
      if (long_hold_pending) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold_pending = 1'b0;
      end else if (hold_left == 0 && rx_idle_on && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 12);
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Pairs with nothing queued pass through untouched.
  task automatic test_empty_passthrough();
    send_request(make_item(pvd_pkg::OP_EMBED, 8'hFF, 1'b1, 8'd0, 8'd255));
    send_request(make_item(pvd_pkg::OP_EMBED, 8'h00, 1'b0, 8'd255, 8'd255));
  endtask

  // Partial buffer, starved pair, full buffer with a dropped end byte, and one
  // pair from every difference range including clamped corners.
  task automatic test_buffer_extremes();
    logic [7:0] fill_bytes[7] = '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h80, 8'h01, 8'h7E};
    logic [7:0] pair_a[8] = '{8'd255, 8'd0, 8'd128, 8'd255, 8'd10, 8'd50, 8'd200, 8'd255};
    logic [7:0] pair_b[8] = '{8'd255, 8'd0, 8'd120, 8'd247, 8'd40, 8'd90, 8'd100, 8'd0};
    send_request(make_item(pvd_pkg::OP_APPEND, 8'hC3, 1'b0, 8'd17, 8'd200));
    send_request(make_item(pvd_pkg::OP_EMBED, 8'h00, 1'b0, 8'd0, 8'd255));
    // One bit left, the pair needs three and no end has come.
    send_request(make_item(pvd_pkg::OP_EMBED, 8'h00, 1'b0, 8'd0, 8'd0));
    foreach (fill_bytes[i]) begin
      send_request(make_item(pvd_pkg::OP_APPEND, fill_bytes[i], 1'b0, 8'($urandom),
                             8'($urandom)));
    end
    // The buffer cannot take another byte; its end flag must be ignored.
    send_request(make_item(pvd_pkg::OP_APPEND, 8'h81, 1'b1, 8'd255, 8'd0));
    foreach (pair_a[i]) begin
      send_request(make_item(pvd_pkg::OP_EMBED, 8'($urandom), 1'b0, pair_a[i], pair_b[i]));
    end
  endtask

  // Open-message traffic in chunks that cycle through the idling modes.
  task automatic test_random_stream();
    for (int chunk = 0; chunk < 8; chunk++) begin
      tx_idle_on = (chunk % 4) inside {1, 3};
      rx_idle_on = (chunk % 4) >= 2;
      repeat (55) send_stream_item();
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming.
  task automatic test_output_backpressure();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    long_hold_pending = 1'b1;
    repeat (40) send_stream_item();
  endtask

  task automatic test_drain_pause();
    wait_for_results();
  endtask

  // Close the message, run it out through a short final field, then check that
  // later bytes are dropped and later pairs pass through.
  task automatic test_message_end();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    while (msg_bits.size() > pvd_pkg::BUFFER_BITS - 8) send_request(random_pair());
    send_request(make_item(pvd_pkg::OP_APPEND, 8'($urandom), 1'b1, 8'($urandom),
                           8'($urandom)));
    while (!msg_done) begin
      if (msg_bits.size() <= 6)
        send_request(make_item(pvd_pkg::OP_EMBED, 8'($urandom), 1'b0, 8'd255, 8'd0));
      else
        send_request(random_pair());
    end
    send_request(make_item(pvd_pkg::OP_APPEND, 8'($urandom), 1'b1, 8'd3, 8'd250));
    repeat (10) send_request(random_pair());
  endtask

  // Test sequence.
  initial begin
    rst_ni              <= 1'b0;
    req_ch.valid        <= 1'b0;
    req_ch.opcode       <= pvd_pkg::OP_APPEND;
    req_ch.message_byte <= 8'd0;
    req_ch.message_end  <= 1'b0;
    req_ch.first_value  <= 8'd0;
    req_ch.second_value <= 8'd0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_passthrough();
    test_buffer_extremes();
    test_random_stream();
    test_output_backpressure();
    test_drain_pause();
    test_message_end();

    wait_for_results();
    repeat (8) @(posedge clk_i);

    $display("Covered %0d requests: %0d bytes queued, %0d dropped, %0d pairs embedded,",
             requests_sent, status_hits[pvd_pkg::ST_BYTE_OK],
             status_hits[pvd_pkg::ST_OVERFLOW],
             status_hits[pvd_pkg::ST_EMBEDDED] + status_hits[pvd_pkg::ST_COMPLETE]);
    $display("%0d passed through, message completed %0d time(s), %0d cycles.",
             status_hits[pvd_pkg::ST_PASS], status_hits[pvd_pkg::ST_COMPLETE],
             cycle_count);
    if (fail_count == 0) begin
      $display("[pvd_pair_embedder_core] OK");
    end else begin
      $display("[pvd_pair_embedder_core] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/pvd_pkg.sv
hw/rtl/pvd_req_if.sv
hw/rtl/pvd_rsp_if.sv
hw/rtl/pvd_front.sv
hw/rtl/pvd_queue.sv
hw/rtl/pvd_back.sv
hw/rtl/pvd_pair_embedder_core.sv
bench/pvd_pair_embedder_core_test.sv
